/* src/qec_pkg.sv */
// ============================================================================
// qec_pkg
// Shared types, codes and constants of the quadrature encoder counter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package qec_pkg;

  // Default width of the saturating step counter
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Counts-per-revolution register
  localparam int unsigned CPR_WIDTH = 13;
  localparam logic [CPR_WIDTH-1:0] CPR_RESET = 13'd96;

  // Angle arithmetic
  localparam int unsigned DEG_WIDTH = 9;
  localparam logic [DEG_WIDTH-1:0] DEG_FULL = 9'd360;
  // Width of remainder times 360
  localparam int unsigned PROD_WIDTH = CPR_WIDTH + DEG_WIDTH;
  // Partial remainder of the divider, one bit above the divisor
  localparam int unsigned REM_WIDTH = CPR_WIDTH + 1;

  // Item function codes
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_STATUS = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Decoded step of one AB transition
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_CW   = 2'd1,
    STEP_CCW  = 2'd2
  } step_e;

  // Input item
  typedef struct packed {
    logic [1:0] func;
    logic       level_a;
    logic       level_b;
    logic       level_switch;
  } qec_in_t;

  // Result item
  typedef struct packed {
    logic                  direction;
    logic signed [31:0]    step_count;
    logic [DEG_WIDTH-1:0]  angle_deg;
    logic                  button_pressed;
  } qec_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // apply the accepted item to the state
    logic load_rem;  // start count magnitude modulo counts_per_rev
    logic div_step;  // one restoring divide iteration
    logic load_ang;  // multiply remainder by 360, start second divide
    logic out_load;  // write the result register
  } qec_cmd_t;

  // Classify the transition from the previous AB pair to the current one
  function automatic step_e ab_step(input logic [1:0] prev, input logic [1:0] cur);
    step_e s;
    unique case ({prev, cur})
      4'b0001, 4'b0111, 4'b1110, 4'b1000: s = STEP_CW;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: s = STEP_CCW;
      default:                            s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* src/qec_ctrl.sv */
// ============================================================================
// qec_ctrl
// Sequencer: accepts an item, runs the two divide passes of the angle and
// hands the result to the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qec_ctrl #(
  parameter int unsigned COUNT_WIDTH = qec_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output qec_pkg::qec_cmd_t      cmd_o
);
  import qec_pkg::*;

  localparam int unsigned DivWidth = (COUNT_WIDTH > PROD_WIDTH) ? COUNT_WIDTH : PROD_WIDTH;
  localparam int unsigned CntWidth = $clog2(DivWidth);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_REM  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ANG  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                in_xfer;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state, iteration count and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.take = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load_rem = 1'b1;
        cnt_d          = CntWidth'(COUNT_WIDTH - 1);
        state_d        = ST_REM;
      end
      ST_REM: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CntWidth'(1);
        if (cnt_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.load_ang = 1'b1;
        cnt_d          = CntWidth'(PROD_WIDTH - 1);
        state_d        = ST_ANG;
      end
      ST_ANG: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CntWidth'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the result register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid: drop on transfer, set on load
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* src/qec_dpath.sv */
// ============================================================================
// qec_dpath
// Encoder state, saturating step counter, shared restoring divider for the
// angle, and the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qec_dpath #(
  parameter int unsigned COUNT_WIDTH = qec_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire qec_pkg::qec_in_t                in_data_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [qec_pkg::CPR_WIDTH-1:0]   cfg_wdata_i,
  input  wire qec_pkg::qec_cmd_t               cmd_i,
  output qec_pkg::qec_out_t                    out_data_o
);
  import qec_pkg::*;

  localparam int unsigned DivWidth = (COUNT_WIDTH > PROD_WIDTH) ? COUNT_WIDTH : PROD_WIDTH;
  localparam logic signed [COUNT_WIDTH-1:0] CountMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CountMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  // Configuration and encoder state
  logic [CPR_WIDTH-1:0]          cpr_q;
  logic [1:0]                    prev_ab_q, prev_ab_d;
  logic                          dir_q, dir_d;
  logic signed [COUNT_WIDTH-1:0] step_q, step_d;
  logic                          press_q, press_d;
  logic                          prev_sw_q, prev_sw_d;
  logic                          button_q, button_d;

  // Divider
  logic [DivWidth-1:0]   dvd_q;
  logic [REM_WIDTH-1:0]  rem_q;
  logic [REM_WIDTH-1:0]  rem_sh;
  logic [REM_WIDTH-1:0]  divisor;
  logic                  ge;
  logic [COUNT_WIDTH-1:0] mag;
  logic [PROD_WIDTH-1:0] prod;

  // Result
  logic                  neg;
  logic [DEG_WIDTH-1:0]  quot;
  logic [DEG_WIDTH-1:0]  angle;
  logic signed [63:0]    step_ext;
  qec_out_t              out_q;

  step_e                 step;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= CPR_RESET;
    end else if (cfg_we_i) begin
      cpr_q <= cfg_wdata_i;
    end
  end

  assign step = ab_step(prev_ab_q, {in_data_i.level_a, in_data_i.level_b});

  // Apply an accepted item to the encoder state
  always_comb begin
    prev_ab_d = prev_ab_q;
    dir_d     = dir_q;
    step_d    = step_q;
    press_d   = press_q;
    prev_sw_d = prev_sw_q;
    button_d  = button_q;
    if (cmd_i.take) begin
      button_d = 1'b0;
      unique case (in_data_i.func)
        FUNC_SAMPLE: begin
          if (step == STEP_CW) begin
            dir_d = 1'b0;
            if (step_q != CountMax) begin
              step_d = step_q + COUNT_WIDTH'(1);
            end
          end else if (step == STEP_CCW) begin
            dir_d = 1'b1;
            if (step_q != CountMin) begin
              step_d = step_q - COUNT_WIDTH'(1);
            end
          end
          prev_ab_d = {in_data_i.level_a, in_data_i.level_b};
          if (in_data_i.level_switch && !prev_sw_q) begin
            press_d = 1'b1;
          end
          prev_sw_d = in_data_i.level_switch;
        end
        FUNC_STATUS: begin
          button_d = press_q;
          press_d  = 1'b0;
        end
        FUNC_CLEAR: begin
          step_d    = '0;
          dir_d     = 1'b0;
          press_d   = 1'b0;
          prev_ab_d = 2'b00;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ab_q <= 2'b00;
      dir_q     <= 1'b0;
      step_q    <= '0;
      press_q   <= 1'b0;
      prev_sw_q <= 1'b0;
      button_q  <= 1'b0;
    end else begin
      prev_ab_q <= prev_ab_d;
      dir_q     <= dir_d;
      step_q    <= step_d;
      press_q   <= press_d;
      prev_sw_q <= prev_sw_d;
      button_q  <= button_d;
    end
  end

  // Count magnitude; the most negative count maps to its unsigned value
  assign neg = step_q[COUNT_WIDTH-1];
  assign mag = neg ? (~$unsigned(step_q) + COUNT_WIDTH'(1)) : $unsigned(step_q);

  // Zero counts per revolution divides by one
  assign divisor = (cpr_q == '0) ? REM_WIDTH'(1) : {1'b0, cpr_q};

  // One restoring divide step: quotient bits shift in at the bottom
  assign rem_sh = {rem_q[REM_WIDTH-2:0], dvd_q[DivWidth-1]};
  assign ge     = (rem_sh >= divisor);

  // Remainder times 360, registered into the divider
  assign prod = PROD_WIDTH'(rem_q[CPR_WIDTH-1:0]) * PROD_WIDTH'(DEG_FULL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rem) begin
      dvd_q <= DivWidth'(mag) << (DivWidth - COUNT_WIDTH);
      rem_q <= '0;
    end else if (cmd_i.load_ang) begin
      dvd_q <= DivWidth'(prod) << (DivWidth - PROD_WIDTH);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DivWidth-2:0], ge};
      rem_q <= ge ? (rem_sh - divisor) : rem_sh;
    end
  end

  // Fold a negative angle into 0..359
  assign quot     = dvd_q[DEG_WIDTH-1:0];
  assign angle    = (neg && (quot != '0)) ? (DEG_FULL - quot) : quot;
  assign step_ext = 64'(step_q);

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.direction      <= dir_q;
      out_q.step_count     <= step_ext[31:0];
      out_q.angle_deg      <= angle;
      out_q.button_pressed <= button_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* src/quadrature_encoder_counter.sv */
// ============================================================================
// quadrature_encoder_counter
// Four-count-per-cycle quadrature decoder with saturating step count, angle
// and latched push-switch flag.
// ============================================================================
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one item per
//   transfer; func selects a pin sample, a status read that returns and
//   clears the press flag, or a counter reset.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result per item, in order, showing direction, count, angle and button.
//   cfg_we_i / cfg_wdata_i write counts_per_rev; write only while idle.
// Timing:
//   An item passes from transfer to result through the restoring divider,
//   one bit per cycle, with COUNT_WIDTH steps for the remainder and 22 steps
//   for the angle. One item is processed at a time; the next transfer is
//   taken the cycle after the result is written to the output register.
// Reset: clears the encoder state and count, loads counts_per_rev with 96
//   and empties the output register.
// Stall: a finished result waits in the output register; a new item is still
//   taken, and its computation holds before the output until the register is
//   drained.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module quadrature_encoder_counter #(
  parameter int unsigned COUNT_WIDTH = qec_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire qec_pkg::qec_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output qec_pkg::qec_out_t                   out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [qec_pkg::CPR_WIDTH-1:0]  cfg_wdata_i
);
  import qec_pkg::*;

  qec_cmd_t cmd;

  // Sequencer
  qec_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // State, divider and result register
  qec_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
